// ===== design/irtl_pkg.sv =====
// Shared types and constants for the IPv4 range table lookup block.
// No dependencies; every design file imports this package.
package irtl_pkg;

   localparam int TABLE_DEPTH = 65536;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_LOOKUP = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_REVERSED  = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] ip_addr;
      logic [31:0] range_low;
      logic [31:0] range_high;
      logic [31:0] location_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] location_out;
   } rsp_type;

   // One table row as seen on the read port.
   typedef struct packed {
      logic [31:0] range_start;
      logic [31:0] range_last;
      logic [31:0] location;
   } entry_type;

   // Access controls from the sequencer to the table storage.
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } table_ctl_type;

endpackage

// ===== design/irtl_table.sv =====
// Range table storage: start, last and location arrays with one write port
// and one registered read port. Depends on irtl_pkg.
module irtl_table
   import irtl_pkg::*;
(
   input  logic          clock,
   input  table_ctl_type ctl,
   input  entry_type     wr_data,
   output entry_type     rd_data
);

   logic [31:0] range_start_mem [TABLE_DEPTH];
   logic [31:0] range_end_mem   [TABLE_DEPTH];
   logic [31:0] location_mem    [TABLE_DEPTH];

   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         range_start_mem[ctl.wr_addr] <= wr_data.range_start;
         range_end_mem[ctl.wr_addr]   <= wr_data.range_last;
         location_mem[ctl.wr_addr]    <= wr_data.location;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff.range_start <= range_start_mem[ctl.rd_addr];
         rd_data_ff.range_last  <= range_end_mem[ctl.rd_addr];
         rd_data_ff.location    <= location_mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ip_range_table_lookup.sv =====
// IPv4 range table lookup: top level with the request sequencer and the
// binary search loop. Depends on irtl_pkg and irtl_table.
//
// Clear, append and unused requests finish in the cycle they are accepted;
// their response strobes in the next cycle. A lookup reads the first and
// last entries and then runs halving steps, each one table read and one
// compare, until the address falls in an end entry, lies outside the
// span's outer bounds, or the span can be split no further.
// The single read port of the table sets the pace of the search. busy
// is high while a lookup runs. Each response is shown for one cycle on
// rsp_strobe and must be taken then; the block never waits for the
// receiver. The table holds no reset: count_ff alone marks which rows
// are valid.
module ip_range_table_lookup
   import irtl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_FETCH_LO = 6'b000010,
      S_FETCH_HI = 6'b000100,
      S_LOAD_HI  = 6'b001000,
      S_CHECK    = 6'b010000,
      S_PROBE    = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] lo_ff, lo_in;
   logic [IDX_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [31:0]      ip_ff, ip_in;
   entry_type        lo_ent_ff, lo_ent_in;
   entry_type        hi_ent_ff, hi_ent_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   table_ctl_type    ctl;
   entry_type        wr_data;
   entry_type        rd_data;
   logic [IDX_W-1:0] span;

   irtl_table u_table (
      .clock   (clock),
      .ctl     (ctl),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   assign span = hi_ff - lo_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      ip_in         = ip_ff;
      lo_ent_in     = lo_ent_ff;
      hi_ent_in     = hi_ent_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      ctl           = '0;
      wr_data.range_start = req_data.range_low;
      wr_data.range_last  = req_data.range_high;
      wr_data.location    = req_data.location_in;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_strobe_in            = 1'b1;
               rsp_data_in.status       = ST_OK;
               rsp_data_in.location_out = '0;
               case (func_type'(req_data.func))
                  FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  FUNC_APPEND: begin
                     if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        rsp_data_in.status = ST_FULL;
                     end else if (req_data.range_high < req_data.range_low) begin
                        rsp_data_in.status = ST_REVERSED;
                     end else begin
                        ctl.wr_en   = 1'b1;
                        ctl.wr_addr = count_ff[IDX_W-1:0];
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_LOOKUP: begin
                     if (count_ff == '0) begin
                        rsp_data_in.status = ST_NOT_FOUND;
                     end else begin
                        // no response yet: the search owns the result
                        rsp_strobe_in = 1'b0;
                        ip_in         = req_data.ip_addr;
                        lo_in         = '0;
                        hi_in         = IDX_W'(count_ff - CNT_W'(1));
                        state_in      = S_FETCH_LO;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FETCH_LO: begin
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = lo_ff;
            state_in    = S_FETCH_HI;
         end
         S_FETCH_HI: begin
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = hi_ff;
            lo_ent_in   = rd_data;
            state_in    = S_LOAD_HI;
         end
         S_LOAD_HI: begin
            hi_ent_in = rd_data;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            rsp_data_in.location_out = '0;
            if (ip_ff < lo_ent_ff.range_start || ip_ff > hi_ent_ff.range_last) begin
               rsp_strobe_in      = 1'b1;
               rsp_data_in.status = ST_NOT_FOUND;
               state_in           = S_IDLE;
            end else if (ip_ff <= lo_ent_ff.range_last) begin
               // lower bound already holds from the outer check
               rsp_strobe_in            = 1'b1;
               rsp_data_in.status       = ST_OK;
               rsp_data_in.location_out = lo_ent_ff.location;
               state_in                 = S_IDLE;
            end else if (ip_ff >= hi_ent_ff.range_start) begin
               rsp_strobe_in            = 1'b1;
               rsp_data_in.status       = ST_OK;
               rsp_data_in.location_out = hi_ent_ff.location;
               state_in                 = S_IDLE;
            end else if (span <= IDX_W'(1)) begin
               // hi never drops below lo, so this also covers hi == lo
               rsp_strobe_in      = 1'b1;
               rsp_data_in.status = ST_NOT_FOUND;
               state_in           = S_IDLE;
            end else begin
               mid_in      = lo_ff + (span >> 1);
               ctl.rd_en   = 1'b1;
               ctl.rd_addr = lo_ff + (span >> 1);
               state_in    = S_PROBE;
            end
         end
         S_PROBE: begin
            if (ip_ff < rd_data.range_start) begin
               hi_in     = mid_ff;
               hi_ent_in = rd_data;
            end else begin
               lo_in     = mid_ff;
               lo_ent_in = rd_data;
            end
            state_in = S_CHECK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      ip_ff       <= ip_in;
      lo_ent_ff   <= lo_ent_in;
      hi_ent_ff   <= hi_ent_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ip_range_table_lookup: clear, append and lookup requests
// checked against an in-bench range table and search. Depends on irtl_pkg and the design.
module tb_top;
   import irtl_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   ip_range_table_lookup DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Predicted table contents, updated as each request is accepted
   logic [31:0] tbl_first [TABLE_DEPTH];
   logic [31:0] tbl_last  [TABLE_DEPTH];
   logic [31:0] tbl_loc   [TABLE_DEPTH];
   int unsigned tbl_count = 0;

   rsp_type     pending_answers [$];
   int          err_count = 0;

   // Ranges the stimulus side knows to be stored, for picking lookup addresses
   logic [31:0] known_lo [$];
   logic [31:0] known_hi [$];

   bit          gaps_on = 1'b1;
   int          burst_left = 0;
   int          items_sent = 0;

   // Two-ended binary search over the predicted table
   function automatic bit find_location(input logic [31:0] ip, output logic [31:0] loc);
      int unsigned lo, hi, span, mid;
      loc = '0;
      if (tbl_count == 0)
         return 1'b0;
      lo = 0;
      hi = tbl_count - 1;
      while (1) begin
         if (ip < tbl_first[lo] || ip > tbl_last[hi])
            return 1'b0;
         if (ip >= tbl_first[lo] && ip <= tbl_last[lo]) begin
            loc = tbl_loc[lo];
            return 1'b1;
         end
         if (ip >= tbl_first[hi] && ip <= tbl_last[hi]) begin
            loc = tbl_loc[hi];
            return 1'b1;
         end
         if (hi <= lo)
            return 1'b0;
         span = hi - lo;
         if (span <= 1)
            return 1'b0;
         mid = lo + span / 2;
         if (ip < tbl_first[mid])
            hi = mid;
         else
            lo = mid;
      end
   endfunction

   function automatic rsp_type compute_answer(input req_type r);
      rsp_type     a;
      logic [31:0] loc;
      a.status = ST_OK;
      a.location_out = '0;
      case (func_type'(r.func))
         FUNC_CLEAR: tbl_count = 0;
         FUNC_APPEND: begin
            if (tbl_count >= TABLE_DEPTH)
               a.status = ST_FULL;
            else if (r.range_high < r.range_low)
               a.status = ST_REVERSED;
            else begin
               tbl_first[tbl_count] = r.range_low;
               tbl_last[tbl_count]  = r.range_high;
               tbl_loc[tbl_count]   = r.location_in;
               tbl_count++;
            end
         end
         FUNC_LOOKUP: begin
            if (find_location(r.ip_addr, loc))
               a.location_out = loc;
            else
               a.status = ST_NOT_FOUND;
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      $error("%s mismatch: expected %0h, got %0h", what, want, got);
      err_count++;
   endtask

   always @(posedge clock) begin : watch_rsp
      rsp_type want;
      if (!reset) begin
         // check before predicting: a response never belongs to this edge's request
         if (rsp_strobe) begin
            if (pending_answers.size() == 0) begin
               $error("response with nothing outstanding: status %0d location %0h",
                      rsp_data.status, rsp_data.location_out);
               err_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_data.status !== want.status)
                  flag_mismatch("status", 32'(want.status), 32'(rsp_data.status));
               if (rsp_data.location_out !== want.location_out)
                  flag_mismatch("location_out", want.location_out, rsp_data.location_out);
            end
         end
         if (start && !busy)
            pending_answers.push_back(compute_answer(req_data));
      end
   end

   function automatic req_type random_req();
      req_type r;
      r.func        = 2'($urandom_range(0, 3));
      r.ip_addr     = $urandom;
      r.range_low   = $urandom;
      r.range_high  = $urandom;
      r.location_in = $urandom;
      return r;
   endfunction

   // Drive one request and hold it until accepted; gaps come between bursts
   task automatic issue(input req_type r);
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         start    <= 1'b0;
         req_data <= random_req();
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0)
         burst_left--;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      items_sent++;
      if (r.func == FUNC_CLEAR) begin
         known_lo.delete();
         known_hi.delete();
      end else if (r.func == FUNC_APPEND && known_lo.size() < TABLE_DEPTH
                   && r.range_high >= r.range_low) begin
         known_lo.push_back(r.range_low);
         known_hi.push_back(r.range_high);
      end
   endtask

   task automatic do_clear();
      req_type r;
      r = random_req();
      r.func = FUNC_CLEAR;
      issue(r);
   endtask

   task automatic do_unused();
      req_type r;
      r = random_req();
      r.func = FUNC_NONE;
      issue(r);
   endtask

   task automatic do_append(input logic [31:0] lo, input logic [31:0] hi,
                            input logic [31:0] loc);
      req_type r;
      r = random_req();
      r.func        = FUNC_APPEND;
      r.range_low   = lo;
      r.range_high  = hi;
      r.location_in = loc;
      issue(r);
   endtask

   task automatic do_lookup(input logic [31:0] ip);
      req_type r;
      r = random_req();
      r.func    = FUNC_LOOKUP;
      r.ip_addr = ip;
      issue(r);
   endtask

   task automatic do_reversed();
      logic [31:0] x;
      x = $urandom_range(1, 32'hFFFF_FFFF);
      do_append(x, $urandom_range(0, x - 1), $urandom);
   endtask

   // Mostly near stored ranges: edges, just outside, inside; some anywhere
   function automatic logic [31:0] pick_address();
      int          idx;
      logic [31:0] lo, hi;
      if (known_lo.size() == 0)
         return $urandom;
      idx = $urandom_range(0, known_lo.size() - 1);
      lo  = known_lo[idx];
      hi  = known_hi[idx];
      case ($urandom_range(0, 7))
         0: return lo;
         1: return hi;
         2: return lo - 1;
         3: return hi + 1;
         7: return $urandom;
         default: return lo + $urandom_range(hi - lo);
      endcase
   endfunction

   // Ascending ranges: 0 spread with holes, 1 back to back over the whole space,
   // 2 tiny ranges packed at the bottom or top of the space
   task automatic build_sorted_table(input int n, input int style, input bit noisy);
      longint unsigned step, lo, hi, top;
      step = 64'h1_0000_0000 / n;
      top  = $urandom_range(0, 1) ? 64'd0 : 64'h1_0000_0000 - 3 * n;
      for (int i = 0; i < n; i++) begin
         case (style)
            0: begin
               lo = i * step + $urandom_range(0, step / 3);
               hi = lo + $urandom_range(0, step / 3);
            end
            1: begin
               lo = i * step;
               hi = (i == n - 1) ? 64'hFFFF_FFFF : (i + 1) * step - 1;
            end
            default: begin
               lo = top + 3 * i;
               hi = lo + $urandom_range(0, 1);
            end
         endcase
         if (noisy) begin
            case ($urandom_range(0, 19))
               0: do_reversed();
               1: do_lookup(pick_address());
               2: do_unused();
               default: ;
            endcase
         end
         do_append(lo[31:0], hi[31:0], $urandom);
      end
   endtask

   task automatic test_directed();
      do_lookup(32'h0);
      do_lookup(32'hFFFF_FFFF);
      do_unused();
      do_append(32'hFFFF_FFFF, 32'h0, 32'h1234_5678);
      do_append(32'h0, 32'h0, 32'hFFFF_FFFF);
      do_append(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
      do_lookup(32'h0);
      do_lookup(32'hFFFF_FFFF);
      do_lookup(32'h5);
      do_clear();
      do_lookup(32'h0);
      do_append(32'd100, 32'd200, 32'hA5A5_A5A5);
      do_append(32'd300, 32'd400, 32'h5A5A_5A5A);
      do_append(32'd500, 32'd600, 32'hFFFF_FFFF);
      do_append(32'd700, 32'd800, 32'h0);
      do_lookup(32'd550);
      do_lookup(32'd450);
      do_lookup(32'd99);
      do_lookup(32'd801);
      do_append(32'd5, 32'd4, 32'h7777_7777);
      do_lookup(32'd200);
      do_lookup(32'd300);
      do_unused();
   endtask

   task automatic test_sorted_tables();
      int stop_at, n, sel;
      stop_at = items_sent + 1000;
      while (items_sent < stop_at) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         do_clear();
         sel = $urandom_range(0, 19);
         if (sel < 14)
            n = $urandom_range(1, 8);
         else if (sel < 19)
            n = $urandom_range(9, 40);
         else
            n = $urandom_range(41, 200);
         build_sorted_table(n, $urandom_range(0, 2), 1'b1);
         repeat ($urandom_range(4, 24))
            do_lookup(pick_address());
      end
   endtask

   // Unsorted, overlapping and duplicate entries; the search still runs its course
   task automatic test_unordered_tables();
      logic [31:0] a, b;
      repeat (12) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         do_clear();
         repeat ($urandom_range(1, 12)) begin
            a = $urandom;
            b = $urandom;
            case ($urandom_range(0, 3))
               0: do_append((a < b) ? a : b, (a < b) ? b : a, $urandom);
               1: do_append(a, b, $urandom);
               2: begin
                  if (known_lo.size() != 0)
                     do_append(known_lo[$], known_hi[$], $urandom);
                  else
                     do_append(32'h0, 32'hFFFF_FFFF, $urandom);
               end
               default: do_append(a >> 4, b | 32'hF000_0000, $urandom);
            endcase
         end
         repeat ($urandom_range(4, 12))
            do_lookup(pick_address());
      end
   endtask

   task automatic test_mixed_random();
      req_type r;
      gaps_on = 1'b1;
      repeat (150) begin
         r = random_req();
         if (r.func == FUNC_LOOKUP && $urandom_range(0, 1))
            r.ip_addr = pick_address();
         issue(r);
      end
   endtask

   task automatic test_full_table();
      gaps_on = 1'b0;
      do_clear();
      build_sorted_table(TABLE_DEPTH, 0, 1'b0);
      gaps_on = 1'b1;
      do_append(32'h10, 32'h20, $urandom);
      do_reversed();
      do_lookup(32'h0);
      do_lookup(32'hFFFF_FFFF);
      repeat (40)
         do_lookup(pick_address());
      do_append(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      do_clear();
      do_lookup(32'h0);
      do_append(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      do_lookup($urandom);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_sorted_tables();
      test_unordered_tables();
      test_full_table();
      test_mixed_random();

      @(negedge clock);
      start <= 1'b0;
      while (pending_answers.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (err_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
